[rtl/pdvsc_pkg.sv]
package pdvsc_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned HDG_W   = 15;
  localparam int unsigned FF_W    = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned CMD_XY_W = 14;
  localparam int unsigned CMD_ZH_W = 12;

  localparam int unsigned ERR_W   = POS_W + 1;
  localparam int unsigned DIFF_W  = POS_W + 2;
  localparam int unsigned HERR_W  = HDG_W + 2;
  localparam int unsigned KD50_W  = GAIN_W + 6;
  localparam int unsigned PSUM_W  = GAIN_W + 1 + ERR_W + 1;
  localparam int unsigned DPROD_W = KD50_W + 1 + DIFF_W;
  localparam int unsigned HSUM_W  = GAIN_W + 1 + HERR_W + 1;
  localparam int unsigned ACC_W   = 50;

  localparam int unsigned GAIN_FRAC  = 8;
  localparam int unsigned DERIV_RATE = 50;

  localparam logic signed [HERR_W-1:0] PI_FX     = 17'sd12868;
  localparam logic signed [HERR_W-1:0] TWO_PI_FX = 17'sd25736;
  localparam logic signed [CMD_XY_W-1:0] LIM_XY  = 14'sd6144;
  localparam logic signed [CMD_XY_W-1:0] LIM_ZH  = 14'sd1638;

  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P_X       = 3'd0,
    REG_GAIN_P_Y       = 3'd1,
    REG_GAIN_P_Z       = 3'd2,
    REG_GAIN_D_X       = 3'd3,
    REG_GAIN_D_Y       = 3'd4,
    REG_GAIN_D_Z       = 3'd5,
    REG_GAIN_P_HEADING = 3'd6
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0] GAIN_P_XY_RST = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_P_Z_RST  = 16'd307;
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_P_H_RST  = 16'd256;

  // round half up from LSB 2^-20 to 2^-12, then saturate to +-lim
  function automatic logic signed [CMD_XY_W-1:0] round_clamp(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [CMD_XY_W-1:0] lim
  );
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] lim_w;
    logic signed [CMD_XY_W-1:0] res;
    lim_w = ACC_W'(lim);
    r = (acc + ACC_W'(signed'(2'sd1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    if (r > lim_w) begin
      res = lim;
    end else if (r < -lim_w) begin
      res = -lim;
    end else begin
      res = r[CMD_XY_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/pd_velocity_setpoint_controller.sv]
// An accepted input request moves through the input, error and product registers into the output register.
// Throughput: one request per cycle while the output is taken; four register stages (input, error,
// product, output) each hold one request, so inputs keep flowing while a finished result waits, until all are full.
// The derivative path uses the error of the previous request, updated as it leaves the input stage.
// Reset (rst_ni low, asynchronous): pipeline empty, previous errors zero, gains at defaults.
module pd_velocity_setpoint_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pdvsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pdvsc_pkg::GAIN_W-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pdvsc_pkg::POS_W-1:0]    target_x_i,
  input  logic signed [pdvsc_pkg::POS_W-1:0]    target_y_i,
  input  logic signed [pdvsc_pkg::POS_W-1:0]    target_z_i,
  input  logic signed [pdvsc_pkg::HDG_W-1:0]    target_heading_i,
  input  logic signed [pdvsc_pkg::POS_W-1:0]    measured_x_i,
  input  logic signed [pdvsc_pkg::POS_W-1:0]    measured_y_i,
  input  logic signed [pdvsc_pkg::POS_W-1:0]    measured_z_i,
  input  logic signed [pdvsc_pkg::HDG_W-1:0]    measured_heading_i,
  input  logic signed [pdvsc_pkg::FF_W-1:0]     ff_vel_x_i,
  input  logic signed [pdvsc_pkg::FF_W-1:0]     ff_vel_y_i,
  input  logic signed [pdvsc_pkg::FF_W-1:0]     ff_heading_rate_i,
  input  logic                                  feedforward_enable_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pdvsc_pkg::CMD_XY_W-1:0] cmd_vel_x_o,
  output logic signed [pdvsc_pkg::CMD_XY_W-1:0] cmd_vel_y_o,
  output logic signed [pdvsc_pkg::CMD_ZH_W-1:0] cmd_vel_z_o,
  output logic signed [pdvsc_pkg::CMD_ZH_W-1:0] cmd_heading_rate_o
);
  import pdvsc_pkg::*;

  // gain registers
  logic [GAIN_W-1:0] gain_q [NUM_REGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[REG_GAIN_P_X]       <= GAIN_P_XY_RST;
      gain_q[REG_GAIN_P_Y]       <= GAIN_P_XY_RST;
      gain_q[REG_GAIN_P_Z]       <= GAIN_P_Z_RST;
      gain_q[REG_GAIN_D_X]       <= GAIN_D_RST;
      gain_q[REG_GAIN_D_Y]       <= GAIN_D_RST;
      gain_q[REG_GAIN_D_Z]       <= GAIN_D_RST;
      gain_q[REG_GAIN_P_HEADING] <= GAIN_P_H_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN_P_X:       gain_q[REG_GAIN_P_X]       <= cfg_data_i;
        REG_GAIN_P_Y:       gain_q[REG_GAIN_P_Y]       <= cfg_data_i;
        REG_GAIN_P_Z:       gain_q[REG_GAIN_P_Z]       <= cfg_data_i;
        REG_GAIN_D_X:       gain_q[REG_GAIN_D_X]       <= cfg_data_i;
        REG_GAIN_D_Y:       gain_q[REG_GAIN_D_Y]       <= cfg_data_i;
        REG_GAIN_D_Z:       gain_q[REG_GAIN_D_Z]       <= cfg_data_i;
        REG_GAIN_P_HEADING: gain_q[REG_GAIN_P_HEADING] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // derivative gains pre-scaled by the 1/0.02 s rate
  logic [KD50_W-1:0] kd50_x, kd50_y, kd50_z;
  assign kd50_x = KD50_W'(gain_q[REG_GAIN_D_X]) * KD50_W'(DERIV_RATE);
  assign kd50_y = KD50_W'(gain_q[REG_GAIN_D_Y]) * KD50_W'(DERIV_RATE);
  assign kd50_z = KD50_W'(gain_q[REG_GAIN_D_Z]) * KD50_W'(DERIV_RATE);

  // per-stage valid and ready chain
  logic s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  logic s0_rdy, s1_rdy, s2_rdy, out_rdy;
  logic s0_go, s1_go, s2_go, out_go;

  assign out_rdy = !out_valid_q || out_ready_i;
  assign s2_rdy  = !s2_valid_q || out_rdy;
  assign s1_rdy  = !s1_valid_q || s2_rdy;
  assign s0_rdy  = !s0_valid_q || s1_rdy;

  assign in_ready_o = s0_rdy;
  assign s0_go  = in_valid_i && s0_rdy;
  assign s1_go  = s0_valid_q && s1_rdy;
  assign s2_go  = s1_valid_q && s2_rdy;
  assign out_go = s2_valid_q && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_rdy) s0_valid_q  <= in_valid_i;
      if (s1_rdy) s1_valid_q  <= s0_valid_q;
      if (s2_rdy) s2_valid_q  <= s1_valid_q;
      if (out_rdy) out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // input stage
  logic signed [POS_W-1:0] tx_q, ty_q, tz_q, mx_q, my_q, mz_q;
  logic signed [HDG_W-1:0] th_q, mh_q;
  logic signed [FF_W-1:0]  fx0_q, fy0_q, fh0_q;

  always_ff @(posedge clk_i) begin
    if (s0_go) begin
      tx_q  <= target_x_i;
      ty_q  <= target_y_i;
      tz_q  <= target_z_i;
      th_q  <= target_heading_i;
      mx_q  <= measured_x_i;
      my_q  <= measured_y_i;
      mz_q  <= measured_z_i;
      mh_q  <= measured_heading_i;
      fx0_q <= feedforward_enable_i ? ff_vel_x_i : '0;
      fy0_q <= feedforward_enable_i ? ff_vel_y_i : '0;
      fh0_q <= feedforward_enable_i ? ff_heading_rate_i : '0;
    end
  end

  // error stage
  logic signed [ERR_W-1:0]  ex_d, ey_d, ez_d;
  logic signed [ERR_W-1:0]  prev_x_q, prev_y_q, prev_z_q;
  logic signed [DIFF_W-1:0] dfx_d, dfy_d, dfz_d;
  logic signed [HERR_W-1:0] eh_raw, eh_d;

  assign ex_d  = ERR_W'(tx_q) - ERR_W'(mx_q);
  assign ey_d  = ERR_W'(ty_q) - ERR_W'(my_q);
  assign ez_d  = ERR_W'(tz_q) - ERR_W'(mz_q);
  assign dfx_d = DIFF_W'(ex_d) - DIFF_W'(prev_x_q);
  assign dfy_d = DIFF_W'(ey_d) - DIFF_W'(prev_y_q);
  assign dfz_d = DIFF_W'(ez_d) - DIFF_W'(prev_z_q);
  assign eh_raw = HERR_W'(th_q) - HERR_W'(mh_q);

  always_comb begin
    if (eh_raw > PI_FX - 17'sd1) begin
      eh_d = eh_raw - TWO_PI_FX;
    end else if (eh_raw < -(PI_FX - 17'sd1)) begin
      eh_d = eh_raw + TWO_PI_FX;
    end else begin
      eh_d = eh_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
    end else if (s1_go) begin
      prev_x_q <= ex_d;
      prev_y_q <= ey_d;
      prev_z_q <= ez_d;
    end
  end

  logic signed [ERR_W-1:0]  ex_q, ey_q, ez_q;
  logic signed [DIFF_W-1:0] dfx_q, dfy_q, dfz_q;
  logic signed [HERR_W-1:0] eh_q;
  logic signed [FF_W-1:0]   fx1_q, fy1_q, fh1_q;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      ex_q  <= ex_d;
      ey_q  <= ey_d;
      ez_q  <= ez_d;
      dfx_q <= dfx_d;
      dfy_q <= dfy_d;
      dfz_q <= dfz_d;
      eh_q  <= eh_d;
      fx1_q <= fx0_q;
      fy1_q <= fy0_q;
      fh1_q <= fh0_q;
    end
  end

  // product stage
  logic signed [PSUM_W-1:0]  px_d, py_d, pz_d;
  logic signed [DPROD_W-1:0] dx_d, dy_d, dz_d;
  logic signed [HSUM_W-1:0]  ph_d;

  assign px_d = PSUM_W'($signed({1'b0, gain_q[REG_GAIN_P_X]}) * ex_q)
              + (PSUM_W'(fx1_q) <<< GAIN_FRAC);
  assign py_d = PSUM_W'($signed({1'b0, gain_q[REG_GAIN_P_Y]}) * ey_q)
              + (PSUM_W'(fy1_q) <<< GAIN_FRAC);
  assign pz_d = PSUM_W'($signed({1'b0, gain_q[REG_GAIN_P_Z]}) * ez_q);
  assign dx_d = DPROD_W'($signed({1'b0, kd50_x}) * dfx_q);
  assign dy_d = DPROD_W'($signed({1'b0, kd50_y}) * dfy_q);
  assign dz_d = DPROD_W'($signed({1'b0, kd50_z}) * dfz_q);
  assign ph_d = HSUM_W'($signed({1'b0, gain_q[REG_GAIN_P_HEADING]}) * eh_q)
              + (HSUM_W'(fh1_q) <<< GAIN_FRAC);

  logic signed [PSUM_W-1:0]  px_q, py_q, pz_q;
  logic signed [DPROD_W-1:0] dx_q, dy_q, dz_q;
  logic signed [HSUM_W-1:0]  ph_q;

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
      ph_q <= ph_d;
    end
  end

  // sum, round, clamp
  logic signed [ACC_W-1:0]    accx, accy, accz, acch;
  logic signed [CMD_XY_W-1:0] cx_d, cy_d, cz_d, ch_d;

  assign accx = ACC_W'(px_q) + ACC_W'(dx_q);
  assign accy = ACC_W'(py_q) + ACC_W'(dy_q);
  assign accz = ACC_W'(pz_q) + ACC_W'(dz_q);
  assign acch = ACC_W'(ph_q);
  assign cx_d = round_clamp(accx, LIM_XY);
  assign cy_d = round_clamp(accy, LIM_XY);
  assign cz_d = round_clamp(accz, LIM_ZH);
  assign ch_d = round_clamp(acch, LIM_ZH);

  logic signed [CMD_XY_W-1:0] cx_q, cy_q;
  logic signed [CMD_ZH_W-1:0] cz_q, ch_q;

  always_ff @(posedge clk_i) begin
    if (out_go) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d[CMD_ZH_W-1:0];
      ch_q <= ch_d[CMD_ZH_W-1:0];
    end
  end

  assign cmd_vel_x_o        = cx_q;
  assign cmd_vel_y_o        = cy_q;
  assign cmd_vel_z_o        = cz_q;
  assign cmd_heading_rate_o = ch_q;

endmodule

[rtl/pdvsc_checker.sv]
module pdvsc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [pdvsc_pkg::CMD_XY_W-1:0] cmd_vel_x_o,
  input logic signed [pdvsc_pkg::CMD_XY_W-1:0] cmd_vel_y_o,
  input logic signed [pdvsc_pkg::CMD_ZH_W-1:0] cmd_vel_z_o,
  input logic signed [pdvsc_pkg::CMD_ZH_W-1:0] cmd_heading_rate_o
);
  import pdvsc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cmd_vel_x_o)
      && $stable(cmd_vel_y_o) && $stable(cmd_vel_z_o) && $stable(cmd_heading_rate_o))
    else $error("result changed while stalled");

  a_xy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cmd_vel_x_o <= LIM_XY && cmd_vel_x_o >= -LIM_XY
      && cmd_vel_y_o <= LIM_XY && cmd_vel_y_o >= -LIM_XY)
    else $error("xy command outside clamp");

  a_zh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> CMD_XY_W'(cmd_vel_z_o) <= LIM_ZH && CMD_XY_W'(cmd_vel_z_o) >= -LIM_ZH
      && CMD_XY_W'(cmd_heading_rate_o) <= LIM_ZH
      && CMD_XY_W'(cmd_heading_rate_o) >= -LIM_ZH)
    else $error("z or heading command outside clamp");

  a_no_result_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

  // input only stalls behind a held result
  a_in_stall_needs_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

endmodule

bind pd_velocity_setpoint_controller pdvsc_checker u_pdvsc_checker (.*);

[dv/pd_velocity_setpoint_controller_checker.sv]
`timescale 1ns / 100ps

module pd_velocity_setpoint_controller_checker
  import pdvsc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [GAIN_W-1:0]            cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_o,
  input  logic signed [POS_W-1:0]      target_x_i,
  input  logic signed [POS_W-1:0]      target_y_i,
  input  logic signed [POS_W-1:0]      target_z_i,
  input  logic signed [HDG_W-1:0]      target_heading_i,
  input  logic signed [POS_W-1:0]      measured_x_i,
  input  logic signed [POS_W-1:0]      measured_y_i,
  input  logic signed [POS_W-1:0]      measured_z_i,
  input  logic signed [HDG_W-1:0]      measured_heading_i,
  input  logic signed [FF_W-1:0]       ff_vel_x_i,
  input  logic signed [FF_W-1:0]       ff_vel_y_i,
  input  logic signed [FF_W-1:0]       ff_heading_rate_i,
  input  logic                         feedforward_enable_i,
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic signed [CMD_XY_W-1:0]   cmd_vel_x_o,
  input  logic signed [CMD_XY_W-1:0]   cmd_vel_y_o,
  input  logic signed [CMD_ZH_W-1:0]   cmd_vel_z_o,
  input  logic signed [CMD_ZH_W-1:0]   cmd_heading_rate_o,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct {
    logic signed [CMD_XY_W-1:0] vel_x;
    logic signed [CMD_XY_W-1:0] vel_y;
    logic signed [CMD_ZH_W-1:0] vel_z;
    logic signed [CMD_ZH_W-1:0] heading_rate;
  } vel_cmd_t;

  logic [GAIN_W-1:0]       gain [NUM_REGS];
  logic signed [ERR_W-1:0] prev_err_x;
  logic signed [ERR_W-1:0] prev_err_y;
  logic signed [ERR_W-1:0] prev_err_z;
  vel_cmd_t                cmd_q [$];
  int                      mismatches = 0;

  // Kp*e + Kd*50*(e - prev) + ff, all at LSB 2^-20, rounded half up to 2^-12
  function automatic longint axis_term(input longint err, input longint prev,
                                       input longint kp, input longint kd,
                                       input longint ff);
    longint acc;
    acc = kp * err + kd * (err - prev) * longint'(DERIV_RATE) + (ff <<< GAIN_FRAC);
    return (acc + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
  endfunction

  function automatic longint saturate(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic vel_cmd_t pd_velocity_cmd();
    vel_cmd_t c;
    longint   ex, ey, ez, eh;
    longint   fx, fy, fh;
    ex = longint'(target_x_i) - longint'(measured_x_i);
    ey = longint'(target_y_i) - longint'(measured_y_i);
    ez = longint'(target_z_i) - longint'(measured_z_i);
    eh = longint'(target_heading_i) - longint'(measured_heading_i);
    // single wrap only, result may still sit at -pi
    if (eh > longint'(PI_FX) - 1) begin
      eh -= longint'(TWO_PI_FX);
    end else if (eh < 1 - longint'(PI_FX)) begin
      eh += longint'(TWO_PI_FX);
    end
    fx = 0;
    fy = 0;
    fh = 0;
    if (feedforward_enable_i) begin
      fx = longint'(ff_vel_x_i);
      fy = longint'(ff_vel_y_i);
      fh = longint'(ff_heading_rate_i);
    end
    c.vel_x = CMD_XY_W'(saturate(axis_term(ex, prev_err_x, gain[REG_GAIN_P_X],
                                           gain[REG_GAIN_D_X], fx), LIM_XY));
    c.vel_y = CMD_XY_W'(saturate(axis_term(ey, prev_err_y, gain[REG_GAIN_P_Y],
                                           gain[REG_GAIN_D_Y], fy), LIM_XY));
    c.vel_z = CMD_ZH_W'(saturate(axis_term(ez, prev_err_z, gain[REG_GAIN_P_Z],
                                           gain[REG_GAIN_D_Z], 0), LIM_ZH));
    c.heading_rate = CMD_ZH_W'(saturate(axis_term(eh, 0, gain[REG_GAIN_P_HEADING],
                                                  0, fh), LIM_ZH));
    prev_err_x = ERR_W'(ex);
    prev_err_y = ERR_W'(ey);
    prev_err_z = ERR_W'(ez);
    return c;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    vel_cmd_t want;
    if (!rst_ni) begin
      gain[REG_GAIN_P_X]       = GAIN_P_XY_RST;
      gain[REG_GAIN_P_Y]       = GAIN_P_XY_RST;
      gain[REG_GAIN_P_Z]       = GAIN_P_Z_RST;
      gain[REG_GAIN_D_X]       = GAIN_D_RST;
      gain[REG_GAIN_D_Y]       = GAIN_D_RST;
      gain[REG_GAIN_D_Z]       = GAIN_D_RST;
      gain[REG_GAIN_P_HEADING] = GAIN_P_H_RST;
      prev_err_x = '0;
      prev_err_y = '0;
      prev_err_z = '0;
      cmd_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NUM_REGS) begin
        gain[cfg_index_i] = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        cmd_q = {cmd_q, pd_velocity_cmd()};
      end
      if (out_valid_o && out_ready_i) begin
        if (cmd_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no request outstanding", $realtime);
          end
        end else begin
          want = cmd_q.pop_front();
          check_field("cmd_vel_x", want.vel_x, cmd_vel_x_o);
          check_field("cmd_vel_y", want.vel_y, cmd_vel_y_o);
          check_field("cmd_vel_z", want.vel_z, cmd_vel_z_o);
          check_field("cmd_heading_rate", want.heading_rate, cmd_heading_rate_o);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= cmd_q.size();
  end

endmodule

[dv/tb_pd_velocity_setpoint_controller.sv]
`timescale 1ns / 100ps

module tb_pd_velocity_setpoint_controller;
  import pdvsc_pkg::*;

  localparam int LATENCY     = 3;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 200;
  localparam int POS_MAX     = (1 << (POS_W - 1)) - 1;
  localparam int POS_MIN     = -POS_MAX - 1;
  localparam int HDG_MAX     = (1 << (HDG_W - 1)) - 1;
  localparam int HDG_MIN     = -HDG_MAX - 1;
  localparam int FF_MAX      = (1 << (FF_W - 1)) - 1;
  localparam int FF_MIN      = -FF_MAX - 1;
  localparam int PI_I        = int'(PI_FX);
  localparam int XY_LIM      = int'(LIM_XY);
  localparam int ZH_LIM      = int'(LIM_ZH);
  // no register behind this index
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic signed [POS_W-1:0] tgt_x, tgt_y, tgt_z;
    logic signed [HDG_W-1:0] tgt_hdg;
    logic signed [POS_W-1:0] meas_x, meas_y, meas_z;
    logic signed [HDG_W-1:0] meas_hdg;
    logic signed [FF_W-1:0]  ff_x, ff_y, ff_hdg;
    logic                    ff_en;
  } pose_req_t;

  logic                       clk_i;
  logic                       rst_ni               = 1'b0;
  logic                       cfg_valid_i          = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i          = '0;
  logic [GAIN_W-1:0]          cfg_data_i           = '0;
  logic                       in_valid_i           = 1'b0;
  logic                       in_ready_o;
  logic signed [POS_W-1:0]    target_x_i           = '0;
  logic signed [POS_W-1:0]    target_y_i           = '0;
  logic signed [POS_W-1:0]    target_z_i           = '0;
  logic signed [HDG_W-1:0]    target_heading_i     = '0;
  logic signed [POS_W-1:0]    measured_x_i         = '0;
  logic signed [POS_W-1:0]    measured_y_i         = '0;
  logic signed [POS_W-1:0]    measured_z_i         = '0;
  logic signed [HDG_W-1:0]    measured_heading_i   = '0;
  logic signed [FF_W-1:0]     ff_vel_x_i           = '0;
  logic signed [FF_W-1:0]     ff_vel_y_i           = '0;
  logic signed [FF_W-1:0]     ff_heading_rate_i    = '0;
  logic                       feedforward_enable_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i          = 1'b0;
  logic signed [CMD_XY_W-1:0] cmd_vel_x_o;
  logic signed [CMD_XY_W-1:0] cmd_vel_y_o;
  logic signed [CMD_ZH_W-1:0] cmd_vel_z_o;
  logic signed [CMD_ZH_W-1:0] cmd_heading_rate_o;

  int fail_count;
  int pending;
  int sent_cnt   = 0;
  int send_burst = 0;

  pd_velocity_setpoint_controller i_dut (.*);

  pd_velocity_setpoint_controller_checker i_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pose_req_t pose_req(input int tx, ty, tz, th, mx, my, mz, mh,
                                         input int fx, fy, fh, en);
    pose_req_t r;
    r.tgt_x    = POS_W'(tx);
    r.tgt_y    = POS_W'(ty);
    r.tgt_z    = POS_W'(tz);
    r.tgt_hdg  = HDG_W'(th);
    r.meas_x   = POS_W'(mx);
    r.meas_y   = POS_W'(my);
    r.meas_z   = POS_W'(mz);
    r.meas_hdg = HDG_W'(mh);
    r.ff_x     = FF_W'(fx);
    r.ff_y     = FF_W'(fy);
    r.ff_hdg   = FF_W'(fh);
    r.ff_en    = en[0];
    return r;
  endfunction

  // mostly tracking-style requests with bounded error, some raw noise
  function automatic pose_req_t random_req();
    pose_req_t r;
    int        span;
    r.meas_x = POS_W'($urandom);
    r.meas_y = POS_W'($urandom);
    r.meas_z = POS_W'($urandom);
    r.ff_en  = 1'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      r.tgt_x    = POS_W'($urandom);
      r.tgt_y    = POS_W'($urandom);
      r.tgt_z    = POS_W'($urandom);
      r.tgt_hdg  = HDG_W'($urandom);
      r.meas_hdg = HDG_W'($urandom);
      r.ff_x     = FF_W'($urandom);
      r.ff_y     = FF_W'($urandom);
      r.ff_hdg   = FF_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       span = 64;
        1:       span = 1024;
        2:       span = 8192;
        default: span = 1 << 20;
      endcase
      r.tgt_x    = POS_W'(int'(r.meas_x) + int'($urandom_range(0, 2 * span)) - span);
      r.tgt_y    = POS_W'(int'(r.meas_y) + int'($urandom_range(0, 2 * span)) - span);
      r.tgt_z    = POS_W'(int'(r.meas_z) + int'($urandom_range(0, 2 * span)) - span);
      r.tgt_hdg  = HDG_W'(int'($urandom_range(0, 2 * PI_I)) - PI_I);
      r.meas_hdg = HDG_W'(int'($urandom_range(0, 2 * PI_I)) - PI_I);
      r.ff_x     = FF_W'(int'($urandom_range(0, 8192)) - 4096);
      r.ff_y     = FF_W'(int'($urandom_range(0, 8192)) - 4096);
      r.ff_hdg   = FF_W'(int'($urandom_range(0, 2048)) - 1024);
    end
    return r;
  endfunction

  task automatic send_req(input pose_req_t r);
    in_valid_i           <= 1'b1;
    target_x_i           <= r.tgt_x;
    target_y_i           <= r.tgt_y;
    target_z_i           <= r.tgt_z;
    target_heading_i     <= r.tgt_hdg;
    measured_x_i         <= r.meas_x;
    measured_y_i         <= r.meas_y;
    measured_z_i         <= r.meas_z;
    measured_heading_i   <= r.meas_hdg;
    ff_vel_x_i           <= r.ff_x;
    ff_vel_y_i           <= r.ff_y;
    ff_heading_rate_i    <= r.ff_hdg;
    feedforward_enable_i <= r.ff_en;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  task automatic sender_pause();
    int gap;
    gap = 0;
    if (send_burst > 0) begin
      send_burst--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_batch(input int n);
    repeat (n) begin
      send_req(random_req());
      sender_pause();
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic program_gains(input logic [GAIN_W-1:0] kp_x, kp_y, kp_z,
                               input logic [GAIN_W-1:0] kd_x, kd_y, kd_z, kp_hdg);
    logic [GAIN_W-1:0] val [NUM_REGS];
    cfg_idx_e          idx;
    val[REG_GAIN_P_X]       = kp_x;
    val[REG_GAIN_P_Y]       = kp_y;
    val[REG_GAIN_P_Z]       = kp_z;
    val[REG_GAIN_D_X]       = kd_x;
    val[REG_GAIN_D_Y]       = kd_y;
    val[REG_GAIN_D_Z]       = kd_z;
    val[REG_GAIN_P_HEADING] = kp_hdg;
    idx = idx.first();
    do begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_index_i <= REG_UNMAPPED;
    cfg_data_i  <= GAIN_W'($urandom);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    int run;
    bit held;
    run  = 0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && sent_cnt >= HOLD_AT) begin
        // long back-pressure so the pipeline fills and stalls the input
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (run > 0) begin
        run--;
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready_i <= 1'b1;
          @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        if ($urandom_range(0, 39) == 0) run = $urandom_range(20, 60);
      end
    end
  end

  initial begin : stimulus
    pose_req_t dir_q [$];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // x has a small Kd so the first request shows the zero history
    program_gains(16'd256, 16'hFFFF, 16'd128, 16'd3, 16'd0, 16'd0, 16'd256);
    dir_q = {dir_q, pose_req(1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(POS_MAX, POS_MAX, POS_MAX, PI_I, POS_MIN, POS_MIN, POS_MIN,
                             -PI_I, FF_MAX, FF_MAX, FF_MAX, 1)};
    dir_q = {dir_q, pose_req(POS_MIN, POS_MIN, POS_MIN, -PI_I, POS_MAX, POS_MAX, POS_MAX,
                             PI_I, FF_MIN, FF_MIN, FF_MIN, 1)};
    dir_q = {dir_q, pose_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    // z at Kp = 0.5: exact limit, ties just past it, ties near zero
    dir_q = {dir_q, pose_req(0, 0, 2 * ZH_LIM, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 2 * ZH_LIM + 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, -2 * ZH_LIM - 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, -2 * ZH_LIM, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, -2 * ZH_LIM - 2, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    // heading wrap boundaries and out-of-range headings
    dir_q = {dir_q, pose_req(0, 0, 0, PI_I - 1, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 0, PI_I, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 0, 1 - PI_I, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 0, -PI_I, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 0, HDG_MAX, 0, 0, 0, HDG_MIN, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 0, HDG_MIN, 0, 0, 0, HDG_MAX, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 0, ZH_LIM, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(0, 0, 0, -ZH_LIM - 1, 0, 0, 0, 0, 0, 0, 0, 0)};
    // steady x error lands exactly on the limit once the derivative is gone
    dir_q = {dir_q, pose_req(XY_LIM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(XY_LIM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_q = {dir_q, pose_req(XY_LIM, 0, 0, 0, XY_LIM, 0, 0, 0, XY_LIM, -XY_LIM, ZH_LIM,
                             1)};
    dir_q = {dir_q, pose_req(XY_LIM, 0, 0, 0, XY_LIM, 0, 0, 0, FF_MAX, FF_MIN, FF_MAX,
                             0)};
    foreach (dir_q[i]) begin
      send_req(dir_q[i]);
      sender_pause();
    end
    random_batch(150);
    wait_idle();

    program_gains('0, '0, '0, '0, '0, '0, '0);
    random_batch(100);
    wait_idle();

    program_gains('1, '1, '1, '1, '1, '1, '1);
    random_batch(100);
    wait_idle();

    program_gains(GAIN_P_XY_RST, GAIN_P_XY_RST, GAIN_P_Z_RST, GAIN_D_RST, GAIN_D_RST,
                  GAIN_D_RST, GAIN_P_H_RST);
    random_batch(150);
    wait_idle();

    program_gains(GAIN_W'($urandom_range(0, 1023)), GAIN_W'($urandom_range(0, 1023)),
                  GAIN_W'($urandom_range(0, 1023)), GAIN_W'($urandom_range(0, 63)),
                  GAIN_W'($urandom_range(0, 63)), GAIN_W'($urandom_range(0, 63)),
                  GAIN_W'($urandom_range(0, 1023)));
    random_batch(150);
    wait_idle();

    program_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                  GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                  GAIN_W'($urandom));
    random_batch(150);
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
